/* rtl/core/gesc_pkg.sv */
// gesc_pkg: shared types and constants for the graph edge store and cycle checker
// no dependencies; used by every module under rtl/core
package gesc_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int VBITS        = $clog2(MAX_VERTICES);
  localparam int COUNT_BITS   = 4;
  localparam int ADDR_BITS    = 2 * VBITS;
  localparam int DEPTH        = MAX_VERTICES * MAX_VERTICES;
  localparam int VCNT_BITS    = 5;
  localparam int PADDR_BITS   = 3;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_CHECK  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NO_EDGE  = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  localparam logic REG_VERTEX_COUNT = 1'b0;
  localparam logic REG_DIRECTED     = 1'b1;

  typedef struct packed {
    logic                  clear;
    logic                  we;
    logic [ADDR_BITS-1:0]  addr;
    logic [COUNT_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

/* rtl/core/gesc_edge_mem.sv */
// gesc_edge_mem: edge multiplicity memory, one access port, registered read
// per-entry valid bits give zero for entries not written since the last clear
// depends on gesc_pkg
module gesc_edge_mem (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_clear,
  input  gesc_pkg::mem_req_t             req,
  output logic [gesc_pkg::COUNT_BITS-1:0] rd_data
);

  logic [gesc_pkg::COUNT_BITS-1:0] mem [gesc_pkg::DEPTH];
  logic [gesc_pkg::DEPTH-1:0]      valid;
  logic [gesc_pkg::COUNT_BITS-1:0] rdata_q;
  logic                            rvalid_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wr_data;
    end
    rdata_q <= mem[req.addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear || req.clear) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid[req.addr];
      if (req.we) begin
        valid[req.addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

/* rtl/core/gesc_ctrl.sv */
// gesc_ctrl: request sequencer for edge edits, union-find scan and depth-first walk
// reads, modifies and writes the edge memory one entry per access
// depends on gesc_pkg
module gesc_ctrl (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [1:0]                      func,
  input  logic [5:0]                      src_vertex,
  input  logic [5:0]                      dst_vertex,
  input  logic [gesc_pkg::VCNT_BITS-1:0]  vertex_count,
  input  logic                            directed,
  input  logic [gesc_pkg::COUNT_BITS-1:0] rd_data,
  output logic                            busy,
  output logic                            done,
  output logic [1:0]                      status,
  output logic                            has_cycle,
  output gesc_pkg::mem_req_t              mreq
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_E_RD   = 12'b000000000010,
    S_E_WR   = 12'b000000000100,
    S_U_INIT = 12'b000000001000,
    S_U_DRD  = 12'b000000010000,
    S_U_DEV  = 12'b000000100000,
    S_U_RD   = 12'b000001000000,
    S_U_EV   = 12'b000010000000,
    S_D_INIT = 12'b000100000000,
    S_D_STRT = 12'b001000000000,
    S_D_RD   = 12'b010000000000,
    S_D_EV   = 12'b100000000000
  } state_t;

  localparam int VB = gesc_pkg::VBITS;
  localparam int NB = gesc_pkg::VBITS + 1;
  localparam int MV = gesc_pkg::MAX_VERTICES;
  localparam int SB = gesc_pkg::COUNT_BITS + 2;

  state_t             state;
  logic [VB-1:0]      s_q, d_q, u, v, w, top;
  logic               pass, flag, is_add;
  logic [NB-1:0]      start_v, depth;
  logic [VB-1:0]      lu, lv;
  logic [VB-1:0]      label [MV];
  logic [VB-1:0]      stack [MV];
  logic [MV-1:0]      vis, onp;
  logic [NB-1:0]      n_used;
  logic               accept, nz, two_step;
  logic [SB-1:0]      amount, sum;
  logic [gesc_pkg::COUNT_BITS-1:0] new_val;
  logic               sat;
  logic [NB-1:0]      u_inc, v_inc, w_inc, depth_dec, depth_dec2;

  assign n_used = (vertex_count > gesc_pkg::VCNT_BITS'(MV)) ? NB'(MV) : NB'(vertex_count);
  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign nz     = (rd_data != '0);
  assign two_step = !directed && (s_q == d_q);
  assign amount = two_step ? SB'(2) : SB'(1);
  assign sum    = SB'(rd_data) + amount;
  assign sat    = (sum > SB'(gesc_pkg::COUNT_MAX));
  assign u_inc  = NB'(u) + NB'(1);
  assign v_inc  = NB'(v) + NB'(1);
  assign w_inc  = NB'(w) + NB'(1);
  assign depth_dec  = depth - NB'(1);
  assign depth_dec2 = depth - NB'(2);

  always_comb begin
    if (is_add) begin
      new_val = sat ? gesc_pkg::COUNT_MAX : sum[gesc_pkg::COUNT_BITS-1:0];
    end else begin
      new_val = (SB'(rd_data) > amount) ?
                gesc_pkg::COUNT_BITS'(SB'(rd_data) - amount) : '0;
    end
  end

  always_comb begin
    mreq.clear   = accept && (func == gesc_pkg::FUNC_CLEAR);
    mreq.we      = (state == S_E_WR);
    mreq.wr_data = new_val;
    unique case (state)
      S_E_RD, S_E_WR: mreq.addr = pass ? {d_q, s_q} : {s_q, d_q};
      S_U_DRD:        mreq.addr = {u, u};
      S_U_RD:         mreq.addr = {u, v};
      S_D_RD:         mreq.addr = {top, w};
      default:        mreq.addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      status    <= gesc_pkg::ST_OK;
      has_cycle <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            s_q    <= src_vertex[VB-1:0];
            d_q    <= dst_vertex[VB-1:0];
            is_add <= (func == gesc_pkg::FUNC_ADD);
            pass   <= 1'b0;
            flag   <= 1'b0;
            priority case (func)
              gesc_pkg::FUNC_ADD, gesc_pkg::FUNC_REMOVE: begin
                if (src_vertex >= 6'(n_used) || dst_vertex >= 6'(n_used)) begin
                  done      <= 1'b1;
                  status    <= gesc_pkg::ST_RANGE;
                  has_cycle <= 1'b0;
                end else begin
                  state <= S_E_RD;
                end
              end
              gesc_pkg::FUNC_CLEAR: begin
                done      <= 1'b1;
                status    <= gesc_pkg::ST_OK;
                has_cycle <= 1'b0;
              end
              default: begin
                if (n_used == '0) begin
                  done      <= 1'b1;
                  status    <= gesc_pkg::ST_OK;
                  has_cycle <= 1'b0;
                end else if (directed) begin
                  state <= S_D_INIT;
                end else begin
                  state <= S_U_INIT;
                end
              end
            endcase
          end
        end
        S_E_RD: state <= S_E_WR;
        S_E_WR: begin
          if (is_add) begin
            flag <= flag | sat;
          end else if (!pass) begin
            flag <= nz;
          end
          if (!pass && !directed && !two_step) begin
            pass  <= 1'b1;
            state <= S_E_RD;
          end else begin
            done      <= 1'b1;
            has_cycle <= 1'b0;
            state     <= S_IDLE;
            if (is_add) begin
              status <= (flag | sat) ? gesc_pkg::ST_FULL : gesc_pkg::ST_OK;
            end else begin
              status <= (pass ? flag : nz) ? gesc_pkg::ST_OK : gesc_pkg::ST_NO_EDGE;
            end
          end
        end
        S_U_INIT: begin
          for (int k = 0; k < MV; k++) begin
            label[k] <= VB'(k);
          end
          u     <= '0;
          state <= S_U_DRD;
        end
        S_U_DRD: begin
          lu    <= label[u];
          state <= S_U_DEV;
        end
        S_U_DEV: begin
          if (nz) begin
            done <= 1'b1; status <= gesc_pkg::ST_OK; has_cycle <= 1'b1; state <= S_IDLE;
          end else if (u_inc >= n_used) begin
            done <= 1'b1; status <= gesc_pkg::ST_OK; has_cycle <= 1'b0; state <= S_IDLE;
          end else begin
            v     <= u_inc[VB-1:0];
            state <= S_U_RD;
          end
        end
        S_U_RD: begin
          lv    <= label[v];
          state <= S_U_EV;
        end
        S_U_EV: begin
          if (nz && (rd_data != gesc_pkg::COUNT_BITS'(1) || lu == lv)) begin
            done <= 1'b1; status <= gesc_pkg::ST_OK; has_cycle <= 1'b1; state <= S_IDLE;
          end else begin
            if (nz) begin
              for (int k = 0; k < MV; k++) begin
                if (label[k] == lu) begin
                  label[k] <= lv;
                end
              end
              lu <= lv;
            end
            if (v_inc < n_used) begin
              v     <= v_inc[VB-1:0];
              state <= S_U_RD;
            end else begin
              u     <= u_inc[VB-1:0];
              state <= S_U_DRD;
            end
          end
        end
        S_D_INIT: begin
          vis     <= '0;
          onp     <= '0;
          start_v <= '0;
          state   <= S_D_STRT;
        end
        S_D_STRT: begin
          if (start_v >= n_used) begin
            done <= 1'b1; status <= gesc_pkg::ST_OK; has_cycle <= 1'b0; state <= S_IDLE;
          end else if (vis[start_v[VB-1:0]]) begin
            start_v <= start_v + NB'(1);
          end else begin
            stack[0]              <= start_v[VB-1:0];
            depth                 <= NB'(1);
            vis[start_v[VB-1:0]]  <= 1'b1;
            onp[start_v[VB-1:0]]  <= 1'b1;
            top                   <= start_v[VB-1:0];
            w                     <= '0;
            state                 <= S_D_RD;
          end
        end
        S_D_RD: state <= S_D_EV;
        S_D_EV: begin
          if (nz && onp[w]) begin
            done <= 1'b1; status <= gesc_pkg::ST_OK; has_cycle <= 1'b1; state <= S_IDLE;
          end else if (nz && !vis[w] && depth < NB'(MV)) begin
            stack[depth[VB-1:0]] <= w;
            depth                <= depth + NB'(1);
            vis[w]               <= 1'b1;
            onp[w]               <= 1'b1;
            top                  <= w;
            w                    <= '0;
            state                <= S_D_RD;
          end else if (w_inc < n_used) begin
            w     <= w_inc[VB-1:0];
            state <= S_D_RD;
          end else begin
            onp[top] <= 1'b0;
            depth    <= depth_dec;
            w        <= '0;
            if (depth_dec == '0) begin
              start_v <= start_v + NB'(1);
              state   <= S_D_STRT;
            end else begin
              top   <= stack[depth_dec2[VB-1:0]];
              state <= S_D_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) || $past(start))) else $error("result without a transaction");

  a_path_visited: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_RD) |-> ((onp & ~vis) == '0)) else $error("path mark on unvisited vertex");

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_EV) |-> (depth <= NB'(MV) && depth != '0)) else $error("walk depth out of range");

endmodule

/* rtl/core/graph_edge_store_cycle_check_top.sv */
// graph_edge_store_cycle_check_top: register port, sequencer and edge memory
// depends on gesc_pkg, gesc_edge_mem, gesc_ctrl
//
//  channel  | handshake                      | payload
//  request  | start, busy                    | func, src_vertex, dst_vertex
//  result   | done (one-cycle strobe)        | status, has_cycle
//  config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// add and remove take a read and a write step per entry touched
// clear, range errors and checks on an empty graph raise done in the cycle after the request
// undirected check: a read and an evaluate step per upper-triangle entry, diagonal included
// directed check: a read and an evaluate step per edge-memory read of the walk, as the memory has a single port
// rst clears the store at once through per-entry valid bits; results cannot be stalled
module graph_edge_store_cycle_check_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gesc_pkg::PADDR_BITS-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            start,
  input  logic [1:0]                      func,
  input  logic [5:0]                      src_vertex,
  input  logic [5:0]                      dst_vertex,
  output logic                            busy,
  output logic                            done,
  output logic [1:0]                      status,
  output logic                            has_cycle
);

  logic [gesc_pkg::VCNT_BITS-1:0]  vertex_count;
  logic                            directed;
  logic                            cfg_wr;
  logic [gesc_pkg::COUNT_BITS-1:0] rd_data;
  gesc_pkg::mem_req_t              mreq;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= '0;
      directed     <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == gesc_pkg::REG_VERTEX_COUNT) begin
        vertex_count <= pwdata[gesc_pkg::VCNT_BITS-1:0];
      end else begin
        directed <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == gesc_pkg::REG_DIRECTED) begin
      prdata = {31'd0, directed};
    end else begin
      prdata = {{(32 - gesc_pkg::VCNT_BITS){1'b0}}, vertex_count};
    end
  end

  gesc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .func         (func),
    .src_vertex   (src_vertex),
    .dst_vertex   (dst_vertex),
    .vertex_count (vertex_count),
    .directed     (directed),
    .rd_data      (rd_data),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .has_cycle    (has_cycle),
    .mreq         (mreq)
  );

  gesc_edge_mem u_mem (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_wr),
    .req       (mreq),
    .rd_data   (rd_data)
  );

endmodule

/* tb/graph_edge_store_cycle_check_top_tb.sv */
// testbench for graph_edge_store_cycle_check_top: directed table, then random edge requests
// depends on gesc_pkg and the rtl under rtl/core; checks each result against a local model or the typed table outcome
`timescale 1ns / 1ps

module graph_edge_store_cycle_check_top_tb;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [gesc_pkg::PADDR_BITS-1:0] paddr = '0;
  logic [31:0]                     pwdata = '0;
  logic [31:0]                     prdata;
  logic                            pready;
  logic                            start = 1'b0;
  logic [1:0]                      func = 2'd0;
  logic [5:0]                      src_vertex = '0;
  logic [5:0]                      dst_vertex = '0;
  logic                            busy;
  logic                            done;
  logic [1:0]                      status;
  logic                            has_cycle;

  graph_edge_store_cycle_check_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #200ms;
    $display("graph_edge_store_cycle_check_top_tb failed");
    $finish;
  end

  typedef struct {
    gesc_pkg::status_t st;
    logic              cyc;
  } outcome_t;

  typedef struct {
    bit                is_cfg;
    int                vc;
    bit                dir;
    gesc_pkg::func_t   f;
    int                s;
    int                d;
    bit                typed;
    gesc_pkg::status_t st;
    logic              cyc;
  } row_t;

  outcome_t pending_results[$];
  int       errors = 0;
  bit       no_idle = 0;

  // edge store model
  logic [gesc_pkg::COUNT_BITS-1:0] mult [gesc_pkg::MAX_VERTICES][gesc_pkg::MAX_VERTICES];
  logic [4:0]                      vcnt_m;
  logic                            dir_m;
  int                              parent [gesc_pkg::MAX_VERTICES];
  int                              stk [gesc_pkg::MAX_VERTICES];

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void wipe_edges();
    foreach (mult[a, b]) mult[a][b] = '0;
  endfunction

  function automatic bit raise_mult(int a, int b, int amt);
    int v;
    v = mult[a][b] + amt;
    if (v > gesc_pkg::COUNT_MAX) begin
      mult[a][b] = gesc_pkg::COUNT_MAX;
      return 1;
    end
    mult[a][b] = v[gesc_pkg::COUNT_BITS-1:0];
    return 0;
  endfunction

  function automatic bit lower_mult(int a, int b, int amt);
    int v;
    int r;
    v = mult[a][b];
    r = (v > amt) ? v - amt : 0;
    mult[a][b] = r[gesc_pkg::COUNT_BITS-1:0];
    return v != 0;
  endfunction

  function automatic int root_of(int v, int n);
    for (int k = 0; k < n && parent[v] != v; k++) v = parent[v] % gesc_pkg::MAX_VERTICES;
    return v;
  endfunction

  function automatic bit loop_undirected(int n);
    int ru, rv;
    for (int v = 0; v < n; v++) parent[v] = v;
    for (int u = 0; u < n; u++) begin
      if (mult[u][u] != 0) return 1;
      for (int v = u + 1; v < n; v++) begin
        if (mult[u][v] == 0) continue;
        if (mult[u][v] >= 2) return 1;
        ru = root_of(u, n);
        rv = root_of(v, n);
        if (ru == rv) return 1;
        parent[ru] = rv;
      end
    end
    return 0;
  endfunction

  function automatic bit loop_directed(int n);
    logic [gesc_pkg::MAX_VERTICES-1:0] seen, on_path;
    int depth, top;
    bit pushed;
    seen = '0;
    on_path = '0;
    for (int r = 0; r < n; r++) begin
      if (seen[r]) continue;
      stk[0] = r;
      depth = 1;
      seen[r] = 1'b1;
      on_path[r] = 1'b1;
      while (depth > 0) begin
        top = stk[depth-1];
        pushed = 0;
        for (int w = 0; w < n; w++) begin
          if (mult[top][w] == 0) continue;
          if (on_path[w]) return 1;
          if (!seen[w] && depth < gesc_pkg::MAX_VERTICES) begin
            seen[w] = 1'b1;
            on_path[w] = 1'b1;
            stk[depth] = w;
            depth++;
            pushed = 1;
            break;
          end
        end
        if (!pushed) begin
          on_path[top] = 1'b0;
          depth--;
        end
      end
    end
    return 0;
  endfunction

  function automatic outcome_t predict_request(gesc_pkg::func_t f, int s, int d);
    outcome_t o;
    int n;
    bit flag;
    n = (vcnt_m > gesc_pkg::MAX_VERTICES) ? gesc_pkg::MAX_VERTICES : vcnt_m;
    o.st = gesc_pkg::ST_OK;
    o.cyc = 1'b0;
    if (f == gesc_pkg::FUNC_ADD || f == gesc_pkg::FUNC_REMOVE) begin
      if (s >= n || d >= n) o.st = gesc_pkg::ST_RANGE;
      else if (f == gesc_pkg::FUNC_ADD) begin
        if (dir_m) flag = raise_mult(s, d, 1);
        else if (s == d) flag = raise_mult(s, s, 2);
        else begin
          flag = raise_mult(s, d, 1);
          flag = raise_mult(d, s, 1) || flag;
        end
        o.st = flag ? gesc_pkg::ST_FULL : gesc_pkg::ST_OK;
      end else begin
        if (dir_m) flag = lower_mult(s, d, 1);
        else if (s == d) flag = lower_mult(s, s, 2);
        else begin
          flag = lower_mult(s, d, 1);
          void'(lower_mult(d, s, 1));
        end
        o.st = flag ? gesc_pkg::ST_OK : gesc_pkg::ST_NO_EDGE;
      end
    end else if (f == gesc_pkg::FUNC_CLEAR) wipe_edges();
    else if (n > 0) o.cyc = dir_m ? loop_directed(n) : loop_undirected(n);
    return o;
  endfunction

  always @(posedge clk) begin
    outcome_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) report("unexpected result", status, 0);
      else begin
        e = pending_results.pop_front();
        if (status !== e.st) report("status", status, e.st);
        if (has_cycle !== e.cyc) report("has_cycle", has_cycle, e.cyc);
      end
    end
  end

  task automatic send_request(gesc_pkg::func_t f, int s, int d, bit typed, outcome_t want);
    int gap;
    outcome_t p;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    src_vertex <= s[5:0];
    dst_vertex <= d[5:0];
    do @(posedge clk); while (busy);
    p = predict_request(f, s, d);
    if (typed) p = want;
    pending_results.insert(pending_results.size(), p);
  endtask

  task automatic apb_access(bit wr, int idx, logic [31:0] val);
    logic [31:0] mask;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= gesc_pkg::PADDR_BITS'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mask = (idx == gesc_pkg::REG_VERTEX_COUNT) ? 32'h1f : 32'h1;
    if (!wr && (prdata & mask) !== (val & mask)) report("prdata", prdata, val & mask);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_graph_mode(int vc, bit dir);
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
    apb_access(1, gesc_pkg::REG_VERTEX_COUNT, vc);
    apb_access(0, gesc_pkg::REG_VERTEX_COUNT, vc);
    apb_access(1, gesc_pkg::REG_DIRECTED, dir);
    apb_access(0, gesc_pkg::REG_DIRECTED, dir);
    vcnt_m = vc[4:0];
    dir_m = dir;
    wipe_edges();
  endtask

  row_t directed_rows [] = '{
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    0,  0, 1, gesc_pkg::ST_RANGE,   0},
    '{0, 0, 0, gesc_pkg::FUNC_CHECK,  0,  0, 1, gesc_pkg::ST_OK,      0},
    '{1, 4, 0, gesc_pkg::FUNC_ADD,    0,  0, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    0,  1, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_CHECK, 63, 63, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    1,  0, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_CHECK,  0,  0, 1, gesc_pkg::ST_OK,      1},
    '{0, 0, 0, gesc_pkg::FUNC_REMOVE, 0,  1, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_REMOVE, 0,  1, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_REMOVE, 1,  0, 1, gesc_pkg::ST_NO_EDGE, 0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,   63,  0, 1, gesc_pkg::ST_RANGE,   0},
    '{0, 0, 0, gesc_pkg::FUNC_REMOVE, 0, 63, 1, gesc_pkg::ST_RANGE,   0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    4,  3, 1, gesc_pkg::ST_RANGE,   0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    1,  2, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    2,  3, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    3,  1, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_CHECK,  0,  0, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_CLEAR, 42, 21, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_CHECK,  0,  0, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    3,  3, 1, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_REMOVE, 3,  3, 1, gesc_pkg::ST_OK,      0},
    '{1, 3, 1, gesc_pkg::FUNC_ADD,    0,  0, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    0,  1, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    1,  2, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_CHECK,  0,  0, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_ADD,    2,  0, 0, gesc_pkg::ST_OK,      0},
    '{0, 0, 0, gesc_pkg::FUNC_CHECK,  0,  0, 0, gesc_pkg::ST_OK,      0}
  };

  int mode_vc []  = '{16, 16, 5, 1, 31, 17, 3, 0, 8, 2, 16};
  bit mode_dir [] = '{0, 1, 1, 0, 1, 0, 0, 1, 1, 0, 1};

  initial begin
    outcome_t want;
    int n, s, d, pick, lim;
    gesc_pkg::func_t f;
    vcnt_m = '0;
    dir_m = 1'b0;
    wipe_edges();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) set_graph_mode(directed_rows[i].vc, directed_rows[i].dir);
      else begin
        want.st = directed_rows[i].st;
        want.cyc = directed_rows[i].cyc;
        send_request(directed_rows[i].f, directed_rows[i].s, directed_rows[i].d,
                     directed_rows[i].typed, want);
      end
    end
    // saturate an undirected self-loop: the eighth add overflows
    set_graph_mode(2, 0);
    for (int k = 0; k < 8; k++) send_request(gesc_pkg::FUNC_ADD, 1, 1, 0, want);

    foreach (mode_vc[m]) begin
      set_graph_mode(mode_vc[m], mode_dir[m]);
      n = (mode_vc[m] > gesc_pkg::MAX_VERTICES) ? gesc_pkg::MAX_VERTICES : mode_vc[m];
      lim = (n > 0) ? n - 1 : 0;
      for (int k = 0; k < 105; k++) begin
        if (k % 35 == 0) no_idle = ($urandom_range(0, 2) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 50) f = gesc_pkg::FUNC_ADD;
        else if (pick < 72) f = gesc_pkg::FUNC_REMOVE;
        else if (pick < 75) f = gesc_pkg::FUNC_CLEAR;
        else f = gesc_pkg::FUNC_CHECK;
        if ($urandom_range(0, 99) < 85 && n > 0) begin
          s = $urandom_range(0, lim);
          d = $urandom_range(0, lim);
        end else begin
          s = $urandom_range(0, 63);
          d = $urandom_range(0, 63);
        end
        send_request(f, s, d, 0, want);
      end
    end

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("graph_edge_store_cycle_check_top_tb passed");
    else $display("graph_edge_store_cycle_check_top_tb failed");
    $finish;
  end

endmodule
